FILE: rtl/core/sdss_pkg.sv
// ----------------------------------------------------------------------------
// sdss_pkg: shared definitions for the segment display serial sender
// Holds the symbol codes, command bytes and the digit to segment table.
// ----------------------------------------------------------------------------
`default_nettype none

package sdss_pkg;

  // Symbol codes carried in the low bits of out_tdata.
  typedef enum logic [1:0] {
    SYM_START = 2'd0,
    SYM_DATA  = 2'd1,
    SYM_ACK   = 2'd2,
    SYM_STOP  = 2'd3
  } sym_t;

  localparam logic [7:0] CMD_DATA_AUTO = 8'h40;
  localparam logic [7:0] CMD_ADDR_0    = 8'hC0;
  localparam logic [7:0] CMD_DISP_ON   = 8'h88;
  localparam logic [7:0] CMD_DISP_OFF  = 8'h80;
  localparam logic [7:0] CHAR_COLON    = 8'h3A;
  localparam logic [7:0] COLON_MASK    = 8'h80;
  localparam logic [7:0] LEVEL_MAX     = 8'd8;

  // Segment pattern for an ASCII digit; anything else is blank.
  function automatic logic [7:0] char_to_seg(input logic [7:0] ch);
    logic [7:0] seg;
    unique case (ch)
      8'h30:   seg = 8'h3F;
      8'h31:   seg = 8'h06;
      8'h32:   seg = 8'h5B;
      8'h33:   seg = 8'h4F;
      8'h34:   seg = 8'h66;
      8'h35:   seg = 8'h6D;
      8'h36:   seg = 8'h7D;
      8'h37:   seg = 8'h07;
      8'h38:   seg = 8'h7F;
      8'h39:   seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/segment_display_serial_sender_core.sv
// ----------------------------------------------------------------------------
// segment_display_serial_sender_core: two-wire display symbol sequencer
// Turns one show or brightness request into its bus symbol sequence.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one request word: tuser carries the action
//   (0 show, 1 brightness), tdata the level and the five characters.
//   The output channel gives one symbol word per transfer: start, data bit
//   (LSB first), ack slot after each byte, and stop; tlast marks the final
//   stop of the request.
//   A brightness request yields 11 words, a show request 58 words. The
//   sequencer shifts one bit of its 48-bit byte register per data symbol
//   and emits at most one word per cycle, holding while the receiver
//   stalls. After a request is accepted the sequencer enters its start
//   state and then registers the first word; it returns to idle as it
//   registers the final stop word.
//   in_tready is high whenever no request is in progress; the next request
//   can be taken while the final stop word still sits in the output
//   register.
//   Reset clears the sequencer and the output valid; no words are lost or
//   repeated when out_tready is held low, the sequencer simply waits.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_display_serial_sender_core
  import sdss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] level, [15:8] char_0, [23:16] char_1, [31:24] char_mid,
  // [39:32] char_2, [47:40] char_3
  input  wire logic [47:0] in_tdata,
  // [0] action
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [1:0] symbol, [2] bit_value, [7:3] zero
  output logic [7:0]       out_tdata,
  output logic             out_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DATA,
    ST_ACK,
    ST_STOP
  } state_t;

  state_t      state_r, state_nxt;
  logic [47:0] shift_r, shift_nxt;
  logic [2:0]  bit_cnt_r, bit_cnt_nxt;
  logic [2:0]  bytes_left_r, bytes_left_nxt;
  logic        second_r, second_nxt;
  logic        out_valid_r, out_valid_nxt;
  sym_t        out_sym_r, out_sym_nxt;
  logic        out_bit_r, out_bit_nxt;
  logic        out_last_r, out_last_nxt;

  logic        in_fire;
  logic        adv;
  logic [7:0]  level;
  logic [2:0]  level_m1;
  logic [7:0]  first_byte;
  logic [7:0]  seg1;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign adv       = !out_valid_r || out_tready;

  assign level    = in_tdata[7:0];
  // Levels 1 to 8 map to 0 to 7; larger requests saturate at the top level.
  assign level_m1 = (level > LEVEL_MAX) ? 3'd7 : (level[2:0] - 3'd1);
  assign seg1     = char_to_seg(in_tdata[23:16]) |
                    ((in_tdata[31:24] == CHAR_COLON) ? COLON_MASK : 8'h00);

  always_comb begin
    if (in_tuser[0]) begin
      first_byte = (level == 8'd0) ? CMD_DISP_OFF : (CMD_DISP_ON | {5'd0, level_m1});
    end else begin
      first_byte = CMD_DATA_AUTO;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    shift_nxt      = shift_r;
    bit_cnt_nxt    = bit_cnt_r;
    bytes_left_nxt = bytes_left_r;
    second_nxt     = second_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_sym_nxt    = out_sym_r;
    out_bit_nxt    = out_bit_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          shift_nxt      = {char_to_seg(in_tdata[47:40]), char_to_seg(in_tdata[39:32]),
                            seg1, char_to_seg(in_tdata[15:8]), CMD_ADDR_0, first_byte};
          second_nxt     = !in_tuser[0];
          bytes_left_nxt = 3'd0;
          state_nxt      = ST_START;
        end
      end
      ST_START: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = SYM_START;
          out_bit_nxt   = 1'b0;
          out_last_nxt  = 1'b0;
          bit_cnt_nxt   = 3'd0;
          state_nxt     = ST_DATA;
        end
      end
      ST_DATA: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = SYM_DATA;
          out_bit_nxt   = shift_r[0];
          out_last_nxt  = 1'b0;
          shift_nxt     = {1'b0, shift_r[47:1]};
          bit_cnt_nxt   = bit_cnt_r + 3'd1;
          if (bit_cnt_r == 3'd7) begin
            state_nxt = ST_ACK;
          end
        end
      end
      ST_ACK: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = SYM_ACK;
          out_bit_nxt   = 1'b1;
          out_last_nxt  = 1'b0;
          if (bytes_left_r == 3'd0) begin
            state_nxt = ST_STOP;
          end else begin
            bytes_left_nxt = bytes_left_r - 3'd1;
            state_nxt      = ST_DATA;
          end
        end
      end
      ST_STOP: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = SYM_STOP;
          out_bit_nxt   = 1'b0;
          out_last_nxt  = !second_r;
          if (second_r) begin
            // Address command plus four digit bytes follow in a new transaction.
            second_nxt     = 1'b0;
            bytes_left_nxt = 3'd4;
            state_nxt      = ST_START;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      second_r    <= second_nxt;
    end
    shift_r      <= shift_nxt;
    bit_cnt_r    <= bit_cnt_nxt;
    bytes_left_r <= bytes_left_nxt;
    out_sym_r    <= out_sym_nxt;
    out_bit_r    <= out_bit_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_bit_r, out_sym_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/core/sdss_checker.sv
// ----------------------------------------------------------------------------
// sdss_checker: port-level checks for the segment display serial sender
// Watches the top-level channels and flags illegal symbol sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module sdss_checker
  import sdss_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  // A stalled output word must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // Once a request is taken the block is busy for at least the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted back to back");

  // The end of a request is always a stop symbol.
  a_last_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[1:0] == SYM_STOP)
    else $error("last word is not a stop symbol");

  // Ack slots are released high, start symbols carry a low bit.
  a_ack_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == SYM_ACK |-> out_tdata[2])
    else $error("ack slot not high");

  a_start_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == SYM_START |-> !out_tdata[2] && !out_tlast)
    else $error("malformed start symbol");

endmodule

bind segment_display_serial_sender_core sdss_checker u_sdss_checker (.*);

`default_nettype wire
